FILE: rtl/mae_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mae_pkg
// Shared types, codes and helper functions of the mini A64 execute unit.
// ----------------------------------------------------------------------------
package mae_pkg;

    localparam int REG_COUNT = 31;
    localparam logic [4:0] LINK_REG = 5'd30;
    localparam logic [63:0] INSN_BYTES = 64'd4;

    typedef enum logic [4:0] {
        MODE_ADD  = 5'd0,
        MODE_SUB  = 5'd1,
        MODE_SUBS = 5'd2,
        MODE_MUL  = 5'd3,
        MODE_SDIV = 5'd4,
        MODE_UDIV = 5'd5,
        MODE_LSL  = 5'd6,
        MODE_LSR  = 5'd7,
        MODE_AND  = 5'd8,
        MODE_ORR  = 5'd9,
        MODE_EOR  = 5'd10,
        MODE_MOV  = 5'd11,
        MODE_LDR  = 5'd12,
        MODE_STR  = 5'd13,
        MODE_CMP  = 5'd14,
        MODE_BEQ  = 5'd15,
        MODE_BNE  = 5'd16,
        MODE_BLT  = 5'd17,
        MODE_BGT  = 5'd18,
        MODE_BLE  = 5'd19,
        MODE_BGE  = 5'd20,
        MODE_B    = 5'd21,
        MODE_BL   = 5'd22,
        MODE_RET  = 5'd23,
        MODE_NOP  = 5'd24,
        MODE_CLZ  = 5'd25,
        MODE_STRB = 5'd26,
        MODE_LDRB = 5'd27
    } mode_t;

    typedef enum logic [1:0] {
        KIND_X  = 2'd0,
        KIND_W  = 2'd1,
        KIND_SP = 2'd2,
        KIND_PC = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        COND_NONE = 2'd0,
        COND_ZERO = 2'd1,
        COND_NEG  = 2'd2,
        COND_POS  = 2'd3
    } cond_t;

    typedef enum logic [1:0] {
        CFG_STACK_BASE = 2'd0,
        CFG_START_SP   = 2'd1,
        CFG_START_PC   = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        CLS_ALU,
        CLS_MUL,
        CLS_DIV,
        CLS_CLZ,
        CLS_MEM,
        CLS_CMP,
        CLS_BR,
        CLS_NOP
    } cls_t;

    typedef struct packed {
        logic [4:0]  mode;
        logic        first_is_const;
        logic [4:0]  first_num;
        logic [1:0]  first_kind;
        logic        second_is_const;
        logic [4:0]  second_num;
        logic [1:0]  second_kind;
        logic        third_is_const;
        logic [4:0]  third_num;
        logic [1:0]  third_kind;
        logic [63:0] immediate;
    } insn_t;

    typedef struct packed {
        insn_t insn;
        cls_t  cls;
    } q_item_t;

    function automatic logic [63:0] sext32(input logic [63:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

    function automatic logic [3:0] lz8(input logic [7:0] v);
        logic [3:0] n;
        logic       hit;
        n   = '0;
        hit = 1'b0;
        for (int i = 7; i >= 0; i--)
        begin
            if (!hit)
            begin
                if (v[i])
                    hit = 1'b1;
                else
                    n = n + 4'd1;
            end
        end
        return n;
    endfunction

endpackage

FILE: rtl/mae_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mae_if
// Valid/ready channels of the execute unit: instruction in, result out.
// ----------------------------------------------------------------------------
interface mae_insn_if;
    logic        valid;
    logic        ready;
    logic [4:0]  mode;
    logic        first_is_const;
    logic [4:0]  first_num;
    logic [1:0]  first_kind;
    logic        second_is_const;
    logic [4:0]  second_num;
    logic [1:0]  second_kind;
    logic        third_is_const;
    logic [4:0]  third_num;
    logic [1:0]  third_kind;
    logic [63:0] immediate;

    modport source (
        output valid, mode, first_is_const, first_num, first_kind,
               second_is_const, second_num, second_kind,
               third_is_const, third_num, third_kind, immediate,
        input  ready
    );
    modport sink (
        input  valid, mode, first_is_const, first_num, first_kind,
               second_is_const, second_num, second_kind,
               third_is_const, third_num, third_kind, immediate,
        output ready
    );
endinterface

interface mae_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] pc_now;
    logic [1:0]  cond_now;
    logic        reg_written;
    logic [63:0] written_value;
    logic        mem_fault;

    modport source (
        output valid, pc_now, cond_now, reg_written, written_value, mem_fault,
        input  ready
    );
    modport sink (
        input  valid, pc_now, cond_now, reg_written, written_value, mem_fault,
        output ready
    );
endinterface

FILE: rtl/mini_a64_execute_unit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mini_a64_execute_unit_top
// Executes one pre-decoded A64-style instruction per transaction and
// returns the resulting pc, condition, written register value and fault.
// ----------------------------------------------------------------------------
// channel   dir   handshake      carries
// insn      in    valid/ready    mode, three operand specs, immediate
// result    out   valid/ready    pc_now, cond_now, reg_written, written_value,
//                                mem_fault
// cfg       in    cfg_we only    stack_base, start_sp, start_pc
//
// after reset the data memory is cleared, one byte a cycle, with insn.ready
// low. a two-entry queue takes instructions while the sequencer works. each
// instruction passes dispatch, three operand reads, execute and writeback;
// mul uses a multiply state, sdiv/udiv a divide state (one quotient bit a
// cycle), clz a count state, and loads and stores a byte-wide memory state.
// writeback waits while the result register is still full.
// ----------------------------------------------------------------------------
module mini_a64_execute_unit_top
    import mae_pkg::*;
#(
    parameter int MEM_BYTES = 4096
)
(
    input  logic         clk,
    input  logic         rst_n,
    mae_insn_if.sink     insn,
    mae_result_if.source result,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data
);

    q_item_t head;
    logic    head_valid;
    logic    head_pop;
    logic    hold;

    mae_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .insn       (insn),
        .hold       (hold),
        .head       (head),
        .head_valid (head_valid),
        .head_pop   (head_pop)
    );

    mae_back #(
        .MEM_BYTES (MEM_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .hold       (hold),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .result     (result)
    );

endmodule

FILE: rtl/mae_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mae_front
// Accepts instructions, tags them with an execution class and queues them.
// ----------------------------------------------------------------------------
module mae_front
    import mae_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    mae_insn_if.sink    insn,
    input  logic        hold,
    output q_item_t     head,
    output logic        head_valid,
    input  logic        head_pop
);

    q_item_t    q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;
    insn_t      in_item;
    cls_t       in_cls;

    always_comb
    begin
        in_item.mode            = insn.mode;
        in_item.first_is_const  = insn.first_is_const;
        in_item.first_num       = insn.first_num;
        in_item.first_kind      = insn.first_kind;
        in_item.second_is_const = insn.second_is_const;
        in_item.second_num      = insn.second_num;
        in_item.second_kind     = insn.second_kind;
        in_item.third_is_const  = insn.third_is_const;
        in_item.third_num       = insn.third_num;
        in_item.third_kind      = insn.third_kind;
        in_item.immediate       = insn.immediate;
    end

    always_comb
    begin
        case (insn.mode)
            MODE_ADD, MODE_SUB, MODE_SUBS, MODE_LSL, MODE_LSR,
            MODE_AND, MODE_ORR, MODE_EOR, MODE_MOV:        in_cls = CLS_ALU;
            MODE_MUL:                                      in_cls = CLS_MUL;
            MODE_SDIV, MODE_UDIV:                          in_cls = CLS_DIV;
            MODE_CLZ:                                      in_cls = CLS_CLZ;
            MODE_LDR, MODE_STR, MODE_LDRB, MODE_STRB:      in_cls = CLS_MEM;
            MODE_CMP:                                      in_cls = CLS_CMP;
            MODE_BEQ, MODE_BNE, MODE_BLT, MODE_BGT, MODE_BLE,
            MODE_BGE, MODE_B, MODE_BL, MODE_RET:           in_cls = CLS_BR;
            default:                                       in_cls = CLS_NOP;
        endcase
    end

    assign insn.ready = (cnt_reg != 2'd2) && !hold;
    assign push       = insn.valid && insn.ready;
    assign head_valid = (cnt_reg != 2'd0);
    assign pop        = head_pop && head_valid;
    assign head       = q_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg].insn <= in_item;
            q_reg[wr_ptr_reg].cls  <= in_cls;
        end
    end

endmodule

FILE: rtl/mae_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mae_back
// Sequencer that reads operands, executes one instruction through the
// shared multiply, divide, count and memory steps, and writes back.
// ----------------------------------------------------------------------------
module mae_back
    import mae_pkg::*;
#(
    parameter int MEM_BYTES = 4096
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  q_item_t      head,
    input  logic         head_valid,
    output logic         head_pop,
    output logic         hold,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    mae_result_if.source result
);

    localparam int AW = $clog2(MEM_BYTES);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD0, S_RD1, S_RD2, S_EXEC,
        S_MUL, S_DIV, S_CLZ, S_MEM, S_WB
    } state_t;

    state_t state_reg;
    q_item_t cur_reg;

    logic [63:0] gp_mem [REG_COUNT];
    logic [REG_COUNT-1:0] gp_vld_reg;
    logic [63:0] rd0_reg, rd1_reg;
    logic [4:0]  raddr0, raddr1;
    logic        gp_we;
    logic [4:0]  gp_waddr;
    logic [63:0] gp_wdata;

    logic [7:0]  dmem [MEM_BYTES];
    logic [7:0]  mem_rd_reg;
    logic        mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]  mem_wdata;
    logic [AW-1:0] clr_reg;

    logic [63:0] sp_reg, pc_reg, base_reg;
    logic [1:0]  cond_reg;
    logic [63:0] a_reg, b_reg, x_reg, addr_reg;
    logic [63:0] res_reg, pcv_reg;
    logic        wr_reg, link_reg, take_reg, fault_reg;

    logic [AW-1:0] off_reg;
    logic [3:0]  size_reg, bidx_reg;
    logic [63:0] stv_reg;

    logic [1:0]  step_reg;
    logic [63:0] p_reg, acc_reg;

    logic [64:0] rem_reg;
    logic [63:0] quo_reg, dvs_reg;
    logic        dneg_reg;
    logic [5:0]  dcnt_reg;

    logic [63:0] cv_reg;
    logic [6:0]  ccnt_reg;
    logic [2:0]  citer_reg;

    logic        out_valid_reg;
    logic [63:0] out_pc_reg, out_val_reg;
    logic [1:0]  out_cond_reg;
    logic        out_wr_reg, out_fault_reg;

    insn_t       ci;
    logic        w1, w2;
    logic [63:0] da, db, dma, dmb;
    logic [3:0]  msize;
    logic [63:0] moff;
    logic        is_load;
    logic [31:0] ma, mb;
    logic [63:0] mprod;
    logic [64:0] rem_s;
    logic        ge;
    logic [63:0] qnew;
    logic [6:0]  ccnt_fin;
    logic [63:0] xs, ys;
    logic        br_take;
    logic [63:0] link_val, bl_tgt;
    logic        wb_go, dst_gp, dst_any;
    logic [63:0] wb_val;
    logic [2:0]  bsel;

    function automatic logic [63:0] opval(input logic c, input logic [1:0] k,
                                          input logic [63:0] raw,
                                          input logic [63:0] imm,
                                          input logic [63:0] sp,
                                          input logic [63:0] pc);
        logic [63:0] v;
        if (c)
            v = imm;
        else
        begin
            case (k)
                KIND_SP: v = sp;
                KIND_PC: v = pc;
                KIND_W:  v = {32'd0, raw[31:0]};
                default: v = raw;
            endcase
        end
        return v;
    endfunction

    assign ci = cur_reg.insn;
    assign w1 = !ci.first_is_const && (ci.first_kind == KIND_W);
    assign w2 = !ci.second_is_const && (ci.second_kind == KIND_W);

    // register file read ports
    always_comb
    begin
        raddr0 = ci.second_num;
        raddr1 = ci.third_num;
        if (state_reg == S_RD1)
            raddr0 = (ci.mode == MODE_RET) ? LINK_REG : ci.first_num;
    end

    always_ff @(posedge clk)
    begin
        rd0_reg <= (raddr0 < 5'(REG_COUNT) && gp_vld_reg[raddr0]) ? gp_mem[raddr0] : '0;
        rd1_reg <= (raddr1 < 5'(REG_COUNT) && gp_vld_reg[raddr1]) ? gp_mem[raddr1] : '0;
        if (gp_we)
            gp_mem[gp_waddr] <= gp_wdata;
    end

    // data memory, one byte per cycle
    assign is_load   = (ci.mode == MODE_LDR) || (ci.mode == MODE_LDRB);
    assign mem_raddr = off_reg + AW'(bidx_reg);
    assign mem_we    = (state_reg == S_CLEAR) || ((state_reg == S_MEM) && !is_load);
    assign mem_waddr = (state_reg == S_CLEAR) ? clr_reg : mem_raddr;
    assign mem_wdata = (state_reg == S_CLEAR) ? 8'd0 : stv_reg[7:0];

    always_ff @(posedge clk)
    begin
        mem_rd_reg <= dmem[mem_raddr];
        if (mem_we)
            dmem[mem_waddr] <= mem_wdata;
    end

    // execute-stage helpers
    always_comb
    begin
        da  = w1 ? sext32(a_reg) : a_reg;
        db  = w1 ? sext32(b_reg) : b_reg;
        dma = da[63] ? (64'd0 - da) : da;
        dmb = db[63] ? (64'd0 - db) : db;

        if ((ci.mode == MODE_LDRB) || (ci.mode == MODE_STRB))
            msize = 4'd1;
        else
            msize = w1 ? 4'd4 : 4'd8;
        moff = addr_reg - base_reg;

        xs = w1 ? sext32(x_reg) : x_reg;
        ys = w2 ? sext32(a_reg) : a_reg;

        case (ci.mode)
            MODE_BEQ: br_take = (cond_reg == COND_ZERO);
            MODE_BNE: br_take = (cond_reg != COND_ZERO);
            MODE_BLT: br_take = (cond_reg == COND_NEG);
            MODE_BGT: br_take = (cond_reg == COND_POS);
            MODE_BLE: br_take = (cond_reg == COND_NEG) || (cond_reg == COND_ZERO);
            MODE_BGE: br_take = (cond_reg == COND_POS) || (cond_reg == COND_ZERO);
            default:  br_take = 1'b1;
        endcase

        // bl writes the link register before the target is read
        link_val = pc_reg + INSN_BYTES;
        if (!ci.first_is_const && ci.first_num == LINK_REG &&
            (ci.first_kind == KIND_X || ci.first_kind == KIND_W))
            bl_tgt = w1 ? {32'd0, link_val[31:0]} : link_val;
        else
            bl_tgt = x_reg;

        case (step_reg)
            2'd1:    begin ma = a_reg[31:0];  mb = b_reg[63:32]; end
            2'd2:    begin ma = a_reg[63:32]; mb = b_reg[31:0];  end
            default: begin ma = a_reg[31:0];  mb = b_reg[31:0];  end
        endcase
        mprod = ma * mb;

        rem_s = {rem_reg[63:0], quo_reg[63]};
        ge    = (rem_s >= {1'b0, dvs_reg});
        qnew  = {quo_reg[62:0], ge};

        if (cv_reg[63:56] == 8'd0)
            ccnt_fin = ccnt_reg + 7'd8;
        else
            ccnt_fin = ccnt_reg + 7'(lz8(cv_reg[63:56]));

        bsel = 3'(bidx_reg - 4'd1);
    end

    // writeback decode
    always_comb
    begin
        wb_go   = (state_reg == S_WB) && (!out_valid_reg || result.ready);
        dst_gp  = wr_reg && !ci.first_is_const &&
                  (ci.first_kind == KIND_X || ci.first_kind == KIND_W) &&
                  (ci.first_num < 5'(REG_COUNT));
        dst_any = dst_gp || (wr_reg && !ci.first_is_const &&
                  (ci.first_kind == KIND_SP || ci.first_kind == KIND_PC));
        wb_val  = w1 ? {32'd0, res_reg[31:0]} : res_reg;

        gp_we    = 1'b0;
        gp_waddr = ci.first_num;
        gp_wdata = wb_val;
        if (wb_go && link_reg)
        begin
            gp_we    = 1'b1;
            gp_waddr = LINK_REG;
            gp_wdata = res_reg;
        end
        else if (wb_go && dst_gp)
            gp_we = 1'b1;
    end

    assign head_pop = (state_reg == S_IDLE) && head_valid;
    assign hold     = (state_reg == S_CLEAR);

    assign result.valid         = out_valid_reg;
    assign result.pc_now        = out_pc_reg;
    assign result.cond_now      = out_cond_reg;
    assign result.reg_written   = out_wr_reg;
    assign result.written_value = out_val_reg;
    assign result.mem_fault     = out_fault_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            gp_vld_reg    <= '0;
            sp_reg        <= '0;
            pc_reg        <= '0;
            base_reg      <= '0;
            cond_reg      <= COND_NONE;
            out_valid_reg <= 1'b0;
            out_pc_reg    <= '0;
            out_cond_reg  <= '0;
            out_wr_reg    <= 1'b0;
            out_val_reg   <= '0;
            out_fault_reg <= 1'b0;
            cur_reg       <= '0;
            a_reg <= '0; b_reg <= '0; x_reg <= '0; addr_reg <= '0;
            res_reg <= '0; pcv_reg <= '0;
            wr_reg <= 1'b0; link_reg <= 1'b0; take_reg <= 1'b0; fault_reg <= 1'b0;
            off_reg <= '0; size_reg <= '0; bidx_reg <= '0; stv_reg <= '0;
            step_reg <= '0; p_reg <= '0; acc_reg <= '0;
            rem_reg <= '0; quo_reg <= '0; dvs_reg <= '0; dneg_reg <= 1'b0;
            dcnt_reg <= '0; cv_reg <= '0; ccnt_reg <= '0; citer_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && result.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(MEM_BYTES - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (head_valid)
                    begin
                        cur_reg   <= head;
                        state_reg <= S_RD0;
                    end
                end
                S_RD0:
                    state_reg <= S_RD1;
                S_RD1:
                begin
                    a_reg <= opval(ci.second_is_const, ci.second_kind, rd0_reg,
                                   ci.immediate, sp_reg, pc_reg);
                    b_reg <= opval(ci.third_is_const, ci.third_kind, rd1_reg,
                                   ci.immediate, sp_reg, pc_reg);
                    // memory base: x and w both use the full register
                    addr_reg <= (ci.second_is_const ? 64'd0 :
                                 (ci.second_kind == KIND_SP) ? sp_reg :
                                 (ci.second_kind == KIND_PC) ? pc_reg : rd0_reg)
                                + ci.immediate;
                    state_reg <= S_RD2;
                end
                S_RD2:
                begin
                    if (ci.mode == MODE_RET)
                        x_reg <= rd0_reg;
                    else
                        x_reg <= opval(ci.first_is_const, ci.first_kind, rd0_reg,
                                       ci.immediate, sp_reg, pc_reg);
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    wr_reg    <= 1'b0;
                    link_reg  <= 1'b0;
                    take_reg  <= 1'b0;
                    fault_reg <= 1'b0;
                    res_reg   <= '0;
                    state_reg <= S_WB;
                    case (cur_reg.cls)
                        CLS_ALU:
                        begin
                            wr_reg <= 1'b1;
                            case (ci.mode)
                                MODE_ADD: res_reg <= a_reg + b_reg;
                                MODE_SUB, MODE_SUBS: res_reg <= a_reg - b_reg;
                                MODE_LSL: res_reg <= a_reg << b_reg[5:0];
                                MODE_LSR: res_reg <= a_reg >> b_reg[5:0];
                                MODE_AND: res_reg <= a_reg & b_reg;
                                MODE_ORR: res_reg <= a_reg | b_reg;
                                MODE_EOR: res_reg <= a_reg ^ b_reg;
                                default:  res_reg <= a_reg;
                            endcase
                        end
                        CLS_MUL:
                        begin
                            step_reg  <= '0;
                            state_reg <= S_MUL;
                        end
                        CLS_DIV:
                        begin
                            rem_reg  <= '0;
                            dcnt_reg <= '0;
                            if (ci.mode == MODE_SDIV)
                            begin
                                quo_reg  <= dma;
                                dvs_reg  <= dmb;
                                dneg_reg <= da[63] ^ db[63];
                                if (db == 64'd0)
                                    wr_reg <= 1'b1;
                                else
                                    state_reg <= S_DIV;
                            end
                            else
                            begin
                                quo_reg  <= a_reg;
                                dvs_reg  <= b_reg;
                                dneg_reg <= 1'b0;
                                if (b_reg == 64'd0)
                                    wr_reg <= 1'b1;
                                else
                                    state_reg <= S_DIV;
                            end
                        end
                        CLS_CLZ:
                        begin
                            cv_reg    <= a_reg;
                            ccnt_reg  <= '0;
                            citer_reg <= '0;
                            state_reg <= S_CLZ;
                        end
                        CLS_MEM:
                        begin
                            if (moff > (64'(MEM_BYTES) - 64'(msize)))
                                fault_reg <= 1'b1;
                            else
                            begin
                                off_reg   <= moff[AW-1:0];
                                size_reg  <= msize;
                                bidx_reg  <= '0;
                                stv_reg   <= x_reg;
                                state_reg <= S_MEM;
                            end
                        end
                        CLS_CMP:
                        begin
                            if ($signed(xs) > $signed(ys))
                                cond_reg <= COND_POS;
                            else if (xs == ys)
                                cond_reg <= COND_ZERO;
                            else
                                cond_reg <= COND_NEG;
                        end
                        CLS_BR:
                        begin
                            take_reg <= br_take;
                            pcv_reg  <= x_reg;
                            if (ci.mode == MODE_BL)
                            begin
                                link_reg <= 1'b1;
                                res_reg  <= link_val;
                                pcv_reg  <= bl_tgt;
                            end
                        end
                        default: ;
                    endcase
                end
                S_MUL:
                begin
                    // 32x32 partial products, low 64 bits only
                    step_reg <= step_reg + 2'd1;
                    p_reg    <= mprod;
                    case (step_reg)
                        2'd0: ;
                        2'd1: acc_reg <= p_reg;
                        2'd2: acc_reg <= acc_reg + {p_reg[31:0], 32'd0};
                        default:
                        begin
                            res_reg   <= acc_reg + {p_reg[31:0], 32'd0};
                            wr_reg    <= 1'b1;
                            state_reg <= S_WB;
                        end
                    endcase
                end
                S_DIV:
                begin
                    rem_reg  <= ge ? (rem_s - {1'b0, dvs_reg}) : rem_s;
                    quo_reg  <= qnew;
                    dcnt_reg <= dcnt_reg + 6'd1;
                    if (dcnt_reg == 6'd63)
                    begin
                        res_reg   <= dneg_reg ? (64'd0 - qnew) : qnew;
                        wr_reg    <= 1'b1;
                        state_reg <= S_WB;
                    end
                end
                S_CLZ:
                begin
                    if (cv_reg[63:56] == 8'd0 && citer_reg != 3'd7)
                    begin
                        ccnt_reg  <= ccnt_fin;
                        cv_reg    <= cv_reg << 8;
                        citer_reg <= citer_reg + 3'd1;
                    end
                    else
                    begin
                        // a w source is zero-extended, so drop the upper half
                        res_reg   <= 64'(w2 ? (ccnt_fin - 7'd32) : ccnt_fin);
                        wr_reg    <= 1'b1;
                        state_reg <= S_WB;
                    end
                end
                S_MEM:
                begin
                    bidx_reg <= bidx_reg + 4'd1;
                    if (is_load)
                    begin
                        if (bidx_reg != 4'd0)
                            res_reg[bsel*8 +: 8] <= mem_rd_reg;
                        if (bidx_reg == size_reg)
                        begin
                            wr_reg    <= 1'b1;
                            state_reg <= S_WB;
                        end
                    end
                    else
                    begin
                        stv_reg <= stv_reg >> 8;
                        if (bidx_reg == size_reg - 4'd1)
                            state_reg <= S_WB;
                    end
                end
                S_WB:
                begin
                    if (wb_go)
                    begin
                        if (link_reg)
                            gp_vld_reg[LINK_REG] <= 1'b1;
                        else if (dst_gp)
                            gp_vld_reg[ci.first_num] <= 1'b1;

                        if (wr_reg && !ci.first_is_const && ci.first_kind == KIND_SP)
                            sp_reg <= res_reg;

                        if (wr_reg && !ci.first_is_const && ci.first_kind == KIND_PC)
                        begin
                            pc_reg     <= res_reg;
                            out_pc_reg <= res_reg;
                        end
                        else if (take_reg)
                        begin
                            pc_reg     <= pcv_reg;
                            out_pc_reg <= pcv_reg;
                        end
                        else
                            out_pc_reg <= pc_reg;

                        out_valid_reg <= 1'b1;
                        out_cond_reg  <= cond_reg;
                        out_wr_reg    <= link_reg || dst_any;
                        out_val_reg   <= link_reg ? res_reg : (dst_any ? wb_val : 64'd0);
                        out_fault_reg <= fault_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_STACK_BASE: base_reg <= cfg_data;
                    CFG_START_SP:   sp_reg   <= cfg_data;
                    CFG_START_PC:   pc_reg   <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

FILE: sim/mae_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mae_tb_pkg
// Memory size shared by the stimulus and the checker, and the result record of the checker.
// ----------------------------------------------------------------------------
package mae_tb_pkg;

    import mae_pkg::*;

    localparam int MEM_BYTES = 4096;

    typedef struct packed {
        logic [63:0] pc_now;
        logic [1:0]  cond_now;
        logic        reg_written;
        logic [63:0] written_value;
        logic        mem_fault;
    } outcome_t;

endpackage

FILE: sim/mae_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mae_tb_if
// Configuration write bundle shared by the stimulus and the checker.
// ----------------------------------------------------------------------------
interface mae_cfg_bus;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;
endinterface

FILE: sim/mae_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mae_checker
// Watches the instruction, result and configuration ports, runs an
// architectural model of the execute unit and compares every result.
// ----------------------------------------------------------------------------
module mae_checker
    import mae_pkg::*;
    import mae_tb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    mae_insn_if       insn,
    mae_result_if     result,
    mae_cfg_bus       cfg,
    output int        fail_count,
    output int        pending
);

    logic [63:0] stack_base;
    logic [63:0] gpr [REG_COUNT];
    logic [63:0] sp_q;
    logic [63:0] pc_q;
    logic [1:0]  cond_q;
    logic [7:0]  mem [MEM_BYTES];
    outcome_t    expected_q[$];

    assign pending = expected_q.size();

    function automatic logic [63:0] rd(logic [4:0] num, logic [1:0] kind);
        if (kind == KIND_SP) return sp_q;
        if (kind == KIND_PC) return pc_q;
        if (num >= REG_COUNT) return 64'd0;
        if (kind == KIND_W) return {32'd0, gpr[num][31:0]};
        return gpr[num];
    endfunction

    function automatic logic [63:0] operand(logic c, logic [4:0] num, logic [1:0] kind,
                                            logic [63:0] imm);
        return c ? imm : rd(num, kind);
    endfunction

    function automatic logic wr(logic c, logic [4:0] num, logic [1:0] kind,
                                logic [63:0] v, inout logic [63:0] shown);
        if (c) return 1'b0;
        if (kind == KIND_SP)
        begin
            sp_q = v;
            shown = v;
            return 1'b1;
        end
        if (kind == KIND_PC)
        begin
            pc_q = v;
            shown = v;
            return 1'b1;
        end
        if (num >= REG_COUNT) return 1'b0;
        if (kind == KIND_W) v = {32'd0, v[31:0]};
        gpr[num] = v;
        shown = v;
        return 1'b1;
    endfunction

    function automatic logic [63:0] signed_quot(logic [63:0] a, logic [63:0] b);
        logic [63:0] ua;
        logic [63:0] ub;
        logic [63:0] q;
        if (b == 0) return 64'd0;
        ua = a[63] ? -a : a;
        ub = b[63] ? -b : b;
        q  = ua / ub;
        return (a[63] != b[63]) ? -q : q;
    endfunction

    function automatic logic [63:0] lead_zeros(logic [63:0] v, int bits);
        logic [63:0] n;
        n = 0;
        for (int i = bits - 1; i >= 0; i--)
        begin
            if (v[i]) break;
            n++;
        end
        return n;
    endfunction

    function automatic logic [63:0] sx32(logic [63:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

    function automatic outcome_t execute(insn_t t);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] res;
        logic [63:0] shown;
        logic [63:0] addr;
        logic [63:0] off;
        logic [63:0] v;
        logic [63:0] x;
        logic [63:0] y;
        int          size;
        logic        wrote;
        logic        fault;
        logic        do_write;
        logic        take;
        outcome_t    o;
        a = operand(t.second_is_const, t.second_num, t.second_kind, t.immediate);
        b = operand(t.third_is_const, t.third_num, t.third_kind, t.immediate);
        res = 0;
        shown = 0;
        wrote = 0;
        fault = 0;
        do_write = 0;
        take = 0;
        case (t.mode)
            MODE_ADD: begin res = a + b; do_write = 1; end
            MODE_SUB, MODE_SUBS: begin res = a - b; do_write = 1; end
            MODE_MUL: begin res = a * b; do_write = 1; end
            MODE_SDIV:
            begin
                if (!t.first_is_const && t.first_kind == KIND_W)
                    res = signed_quot(sx32(a), sx32(b));
                else
                    res = signed_quot(a, b);
                do_write = 1;
            end
            MODE_UDIV: begin res = (b != 0) ? a / b : 64'd0; do_write = 1; end
            MODE_LSL: begin res = a << b[5:0]; do_write = 1; end
            MODE_LSR: begin res = a >> b[5:0]; do_write = 1; end
            MODE_AND: begin res = a & b; do_write = 1; end
            MODE_ORR: begin res = a | b; do_write = 1; end
            MODE_EOR: begin res = a ^ b; do_write = 1; end
            MODE_MOV: begin res = a; do_write = 1; end
            MODE_LDR, MODE_STR, MODE_STRB, MODE_LDRB:
            begin
                // x and w bases both use the full register
                if (t.second_is_const) addr = 0;
                else if (t.second_kind == KIND_SP) addr = sp_q;
                else if (t.second_kind == KIND_PC) addr = pc_q;
                else addr = (t.second_num < REG_COUNT) ? gpr[t.second_num] : 64'd0;
                addr = addr + t.immediate;
                if (t.mode == MODE_STRB || t.mode == MODE_LDRB) size = 1;
                else size = (!t.first_is_const && t.first_kind == KIND_W) ? 4 : 8;
                off = addr - stack_base;
                if (off > 64'(MEM_BYTES - size))
                    fault = 1;
                else if (t.mode == MODE_LDR || t.mode == MODE_LDRB)
                begin
                    for (int i = size; i > 0; i--)
                        res = (res << 8) | 64'(mem[off + i - 1]);
                    do_write = 1;
                end
                else
                begin
                    v = operand(t.first_is_const, t.first_num, t.first_kind, t.immediate);
                    for (int i = 0; i < size; i++)
                    begin
                        mem[off + i] = v[7:0];
                        v = v >> 8;
                    end
                end
            end
            MODE_CMP:
            begin
                x = operand(t.first_is_const, t.first_num, t.first_kind, t.immediate);
                y = a;
                if (!t.first_is_const && t.first_kind == KIND_W) x = sx32(x);
                if (!t.second_is_const && t.second_kind == KIND_W) y = sx32(y);
                if ($signed(x) > $signed(y)) cond_q = COND_POS;
                else if (x == y) cond_q = COND_ZERO;
                else cond_q = COND_NEG;
            end
            MODE_BEQ: take = cond_q == COND_ZERO;
            MODE_BNE: take = cond_q != COND_ZERO;
            MODE_BLT: take = cond_q == COND_NEG;
            MODE_BGT: take = cond_q == COND_POS;
            MODE_BLE: take = cond_q == COND_NEG || cond_q == COND_ZERO;
            MODE_BGE: take = cond_q == COND_POS || cond_q == COND_ZERO;
            MODE_B: take = 1;
            MODE_BL:
            begin
                gpr[LINK_REG] = pc_q + INSN_BYTES;
                wrote = 1;
                shown = gpr[LINK_REG];
                take = 1;
            end
            MODE_RET: pc_q = gpr[LINK_REG];
            MODE_CLZ:
            begin
                res = (!t.second_is_const && t.second_kind == KIND_W) ?
                      lead_zeros(a, 32) : lead_zeros(a, 64);
                do_write = 1;
            end
            default: ;
        endcase
        if (take)
            pc_q = operand(t.first_is_const, t.first_num, t.first_kind, t.immediate);
        if (do_write)
            wrote = wr(t.first_is_const, t.first_num, t.first_kind, res, shown);
        if (!wrote) shown = 0;
        o.pc_now = pc_q;
        o.cond_now = cond_q;
        o.reg_written = wrote;
        o.written_value = shown;
        o.mem_fault = fault;
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        insn_t    t;
        outcome_t got;
        outcome_t want;
        if (!rst_n)
        begin
            stack_base = 0;
            sp_q = 0;
            pc_q = 0;
            cond_q = COND_NONE;
            foreach (gpr[i]) gpr[i] = 0;
            foreach (mem[i]) mem[i] = 0;
            expected_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg.cfg_we)
            begin
                case (cfg.cfg_index)
                    CFG_STACK_BASE: stack_base = cfg.cfg_data;
                    CFG_START_SP:   sp_q = cfg.cfg_data;
                    CFG_START_PC:   pc_q = cfg.cfg_data;
                    default: ;
                endcase
            end
            if (result.valid && result.ready)
            begin
                got = '{result.pc_now, result.cond_now, result.reg_written,
                        result.written_value, result.mem_fault};
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transaction: %p", got);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("result mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            if (insn.valid && insn.ready)
            begin
                t = '{insn.mode, insn.first_is_const, insn.first_num, insn.first_kind,
                      insn.second_is_const, insn.second_num, insn.second_kind,
                      insn.third_is_const, insn.third_num, insn.third_kind,
                      insn.immediate};
                expected_q.push_back(execute(t));
            end
        end
    end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression of the mini A64 execute unit: directed corner instructions,
// then random programs over several memory windows, with random stalls on
// both channels, a long receiver hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module tb
    import mae_pkg::*;
    import mae_tb_pkg::*;
();

    localparam int WATCHDOG = 60000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    bit   quiet;
    bit   hold_off;

    mae_insn_if   insn ();
    mae_result_if result ();
    mae_cfg_bus   cfg ();

    mini_a64_execute_unit_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .insn      (insn),
        .result    (result),
        .cfg_we    (cfg.cfg_we),
        .cfg_index (cfg.cfg_index),
        .cfg_data  (cfg.cfg_data)
    );

    mae_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .insn       (insn),
        .result     (result),
        .cfg        (cfg),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin
        int n;
        result.ready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (hold_off)
            begin
                result.ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 3);
                result.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else
            begin
                result.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // watchdog on accepted transactions
    always @(posedge clk)
    begin
        if (!rst_n || (insn.valid && insn.ready) || (result.valid && result.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("mini_a64_execute_unit_top regression: fail");
            $finish;
        end
    end

    task automatic send(insn_t t);
        int n;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            n = $urandom_range(1, 3);
            insn.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        insn.valid           <= 1'b1;
        insn.mode            <= t.mode;
        insn.first_is_const  <= t.first_is_const;
        insn.first_num       <= t.first_num;
        insn.first_kind      <= t.first_kind;
        insn.second_is_const <= t.second_is_const;
        insn.second_num      <= t.second_num;
        insn.second_kind     <= t.second_kind;
        insn.third_is_const  <= t.third_is_const;
        insn.third_num       <= t.third_num;
        insn.third_kind      <= t.third_kind;
        insn.immediate       <= t.immediate;
        @(posedge clk);
        while (!insn.ready) @(posedge clk);
    endtask

    task automatic drain();
        insn.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_cfg(cfg_idx_t idx, logic [63:0] v);
        cfg.cfg_we    <= 1'b1;
        cfg.cfg_index <= idx;
        cfg.cfg_data  <= v;
        @(posedge clk);
        cfg.cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic insn_t make(mode_t m, logic [1:0] k1, logic [4:0] n1,
                                   logic [1:0] k2, logic [4:0] n2, logic c3,
                                   logic [4:0] n3, logic [63:0] imm);
        insn_t t;
        t = '{m, 1'b0, n1, k1, 1'b0, n2, k2, c3, n3, KIND_X, imm};
        return t;
    endfunction

    function automatic logic [63:0] interesting();
        case ($urandom_range(0, 7))
            0: return 64'd0;
            1: return 64'hFFFF_FFFF_FFFF_FFFF;
            2: return 64'h8000_0000_0000_0000;
            3: return 64'h0000_0000_8000_0000;
            4: return 64'(int'($urandom_range(0, 80)) - 8);
            default: return rand64();
        endcase
    endfunction

    // random instruction; most memory accesses land in or near the window
    function automatic insn_t random_insn(logic [63:0] base);
        insn_t t;
        t = insn_t'(93'({$urandom(), $urandom(), $urandom()}));
        if ($urandom_range(0, 9) != 0) t.mode = 5'($urandom_range(0, 27));
        t.immediate = interesting();
        if ($urandom_range(0, 3) != 0)
        begin
            t.first_num  = 5'($urandom_range(0, 30));
            t.second_num = 5'($urandom_range(0, 30));
            t.third_num  = 5'($urandom_range(0, 30));
        end
        if ($urandom_range(0, 3) != 0) t.first_is_const = 1'b0;
        if (t.mode inside {MODE_LDR, MODE_STR, MODE_LDRB, MODE_STRB} &&
            $urandom_range(0, 4) != 0)
        begin
            t.second_is_const = 1'b1;
            t.immediate = base + 64'(int'($urandom_range(0, MEM_BYTES + 8)) - 4);
        end
        return t;
    endfunction

    initial
    begin
        logic [63:0] base;
        insn_t       t;
        quiet = 1'b0;
        hold_off = 1'b0;
        insn.valid = 1'b0;
        {insn.mode, insn.first_is_const, insn.first_num, insn.first_kind,
         insn.second_is_const, insn.second_num, insn.second_kind,
         insn.third_is_const, insn.third_num, insn.third_kind,
         insn.immediate} = '0;
        cfg.cfg_we = 1'b0;
        cfg.cfg_index = CFG_STACK_BASE;
        cfg.cfg_data = '0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_cfg(CFG_STACK_BASE, 64'h1000);
        write_cfg(CFG_START_SP, 64'h1800);
        write_cfg(CFG_START_PC, 64'h400);

        // directed corners
        send(make(MODE_MOV, KIND_X, 1, KIND_X, 0, 1, 0, 64'h8000_0000_0000_0000) |
             insn_t'({5'd0, 1'b0, 5'd0, 2'd0, 1'b1, 15'd0, 64'd0}));
        send('{MODE_MOV, 1'b0, 5'd2, KIND_X, 1'b1, 5'd0, KIND_X, 1'b1, 5'd0, KIND_X,
               64'hFFFF_FFFF_FFFF_FFFF});
        send(make(MODE_SDIV, KIND_X, 3, KIND_X, 1, 0, 2, 0));
        send(make(MODE_SDIV, KIND_W, 4, KIND_X, 2, 0, 1, 0));
        send(make(MODE_UDIV, KIND_X, 5, KIND_X, 2, 0, 0, 0));
        send(make(MODE_LSL, KIND_X, 6, KIND_X, 2, 1, 0, 64'd127));
        send(make(MODE_LSR, KIND_W, 7, KIND_X, 2, 1, 0, 64'd65));
        send(make(MODE_CLZ, KIND_X, 8, KIND_W, 1, 0, 0, 0));
        send(make(MODE_CLZ, KIND_X, 9, KIND_X, 0, 0, 0, 0));
        send(make(MODE_MOV, KIND_X, 31, KIND_X, 2, 0, 0, 0));
        send(make(MODE_ADD, KIND_SP, 0, KIND_SP, 0, 1, 0, 64'd8));
        send('{MODE_STR, 1'b0, 5'd2, KIND_W, 1'b0, 5'd0, KIND_SP, 1'b1, 5'd0, KIND_X,
               64'hFFFF_FFFF_FFFF_FFF8});
        send('{MODE_LDR, 1'b0, 5'd10, KIND_X, 1'b1, 5'd0, KIND_X, 1'b0, 5'd0, KIND_X,
               64'h1000 + MEM_BYTES - 8});
        send('{MODE_STRB, 1'b1, 5'd0, KIND_X, 1'b1, 5'd0, KIND_X, 1'b0, 5'd0, KIND_X,
               64'h1000 + MEM_BYTES});
        send('{MODE_LDRB, 1'b0, 5'd11, KIND_X, 1'b1, 5'd0, KIND_X, 1'b0, 5'd0, KIND_X,
               64'hFFF});
        send(make(MODE_CMP, KIND_W, 2, KIND_X, 0, 0, 0, 0));
        send(make(MODE_BLT, KIND_X, 2, KIND_X, 0, 0, 0, 0));
        send(make(MODE_SUBS, KIND_X, 12, KIND_X, 2, 0, 2, 0));
        send(make(MODE_MUL, KIND_X, 13, KIND_X, 2, 0, 2, 0));
        send(make(MODE_BL, KIND_PC, 0, KIND_X, 0, 0, 0, 0));
        send(make(MODE_RET, KIND_X, 0, KIND_X, 0, 0, 0, 0));
        send(make(MODE_NOP, KIND_X, 0, KIND_X, 0, 0, 0, 0));
        send(make(MODE_AND, KIND_X, 14, KIND_X, 2, 0, 1, 0));
        send(make(MODE_ORR, KIND_X, 14, KIND_X, 2, 0, 1, 0));
        send(make(MODE_EOR, KIND_X, 14, KIND_X, 2, 0, 1, 0));

        // sender stops until the result channel is empty
        drain();

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: base = 64'h0;
                1: base = 64'hFFFF_FFFF_FFFF_FFFF - MEM_BYTES + 1;
                2: base = 64'hFFFF_FFFF_FFFF_F800;
                default: base = rand64();
            endcase
            write_cfg(CFG_STACK_BASE, base);
            write_cfg(CFG_START_SP, (phase == 1) ? 64'hFFFF_FFFF_FFFF_FFFF : base + 64);
            write_cfg(CFG_START_PC, (phase == 0) ? 64'd0 : rand64());
            if (phase == 1) hold_off = 1'b1;
            if (phase == 4) quiet = 1'b1;
            for (int i = 0; i < 245; i++)
            begin
                t = random_insn(base);
                send(t);
            end
            drain();
        end

        if (fail_count == 0)
            $display("mini_a64_execute_unit_top regression: pass");
        else
            $display("mini_a64_execute_unit_top regression: fail");
        $finish;
    end

endmodule
